FILE: hdl/rbfd_pkg.sv
// ----------------------------------------------------------------------------
// rbfd_pkg
// Shared types and constants of the feedback word decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rbfd_pkg;

  localparam int unsigned ADDRESS_COUNT = 128;
  localparam int unsigned STORE_DEPTH   = 128;
  localparam int unsigned IDX_W         = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W         = 16;
  localparam int unsigned OUT_CNT_W     = 16;
  localparam int unsigned GAP_W         = 16;
  localparam int unsigned NIB_W         = 7;
  localparam int unsigned ADDR_W        = 8;
  localparam int unsigned SAMPLES_W     = 24;
  localparam int unsigned DATA_BITS     = 8;

  localparam logic [ADDR_W-1:0] ADDR_BASE     = 8'd129;
  localparam logic [GAP_W-1:0]  NORMAL_GAP_RST = 16'd6850;
  localparam logic [GAP_W-1:0]  ERROR_GAP_RST  = 16'd10700;

  typedef enum logic {
    MODE_WORD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_e;

  typedef enum logic {
    REG_NORMAL_GAP = 1'b0,
    REG_ERROR_GAP  = 1'b1
  } cfg_reg_e;

  // One status record of an address
  typedef struct packed {
    logic [CNT_W-1:0] msg_cnt;
    logic [CNT_W-1:0] samp_err_cnt;
    logic [CNT_W-1:0] par_err_cnt;
    logic [NIB_W-1:0] nib_lo;
    logic [NIB_W-1:0] nib_hi;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [NIB_W-1:0] payload;
    logic             parity_failed;
    logic             uncertain;
  } vote_t;

endpackage

`default_nettype wire

FILE: hdl/rs_bus_feedback_decoder_core.sv
// ----------------------------------------------------------------------------
// rs_bus_feedback_decoder_core
// Feedback word decoder with per-address message, error and nibble status.
// ----------------------------------------------------------------------------
// Request accept to result valid: RAM read with the request register, then
//   update into the result register. Throughput: one request per cycle
//   while the result channel does not stall; the status RAM has one read and
//   one write port, and a same-address write is forwarded to the next read.
// Reset: counters and nibble stores read as zero through per-entry valid
//   bits, gap selection returns to normal, gap registers to 6850 / 10700.
`timescale 1ns / 1ps
`default_nettype none

module rs_bus_feedback_decoder_core
  import rbfd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // request channel
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 mode_i,
  input  wire logic [ADDR_W-1:0]    pulse_count_i,
  input  wire logic [SAMPLES_W-1:0] samples_i,
  input  wire logic [ADDR_W-1:0]    query_address_i,
  // configuration channel
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic                 cfg_index_i,
  input  wire logic [GAP_W-1:0]     cfg_data_i,
  // result channel
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      address_ok_o,
  output logic [ADDR_W-1:0]         address_o,
  output logic [NIB_W-1:0]          payload_o,
  output logic                      parity_failed_o,
  output logic                      samples_uncertain_o,
  output logic [GAP_W-1:0]          gap_us_o,
  output logic [OUT_CNT_W-1:0]      message_total_o,
  output logic [OUT_CNT_W-1:0]      sampling_error_total_o,
  output logic [OUT_CNT_W-1:0]      parity_error_total_o,
  output logic [NIB_W-1:0]          stored_nibble_low_o,
  output logic [NIB_W-1:0]          stored_nibble_high_o
);

  // configuration
  logic [GAP_W-1:0] normal_gap_q;
  logic [GAP_W-1:0] error_gap_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_gap_q <= NORMAL_GAP_RST;
      error_gap_q  <= ERROR_GAP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_NORMAL_GAP: normal_gap_q <= cfg_data_i;
        REG_ERROR_GAP:  error_gap_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // request decode
  logic              in_acc;
  logic [ADDR_W-1:0] in_addr;
  logic [ADDR_W-1:0] in_addr_m1;
  logic              in_ok;

  assign in_acc     = in_valid_i && in_ready_o;
  assign in_addr    = (mode_e'(mode_i) == MODE_QUERY) ? query_address_i
                                                      : ADDR_BASE - pulse_count_i;
  assign in_addr_m1 = in_addr - ADDR_W'(1);
  assign in_ok      = (in_addr != '0) && (in_addr <= ADDR_W'(ADDRESS_COUNT));

  // stage 1: request register
  logic                 s1_valid_q;
  mode_e                s1_mode_q;
  logic [ADDR_W-1:0]    s1_addr_q;
  logic [IDX_W-1:0]     s1_idx_q;
  logic                 s1_ok_q;
  logic [SAMPLES_W-1:0] s1_samples_q;
  logic                 s1_adv;

  assign s1_adv     = s1_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_mode_q    <= mode_e'(mode_i);
      s1_addr_q    <= in_addr;
      s1_idx_q     <= in_addr_m1[IDX_W-1:0];
      s1_ok_q      <= in_ok;
      s1_samples_q <= samples_i;
    end
  end

  // status store
  entry_t cur_entry;
  entry_t new_entry;
  logic   wr_en;
  vote_t  vote;
  logic   s1_word_ok;

  assign s1_word_ok = (s1_mode_q == MODE_WORD) && s1_ok_q;
  assign wr_en      = s1_adv && s1_word_ok;

  rbfd_status_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_idx_i  (in_addr_m1[IDX_W-1:0]),
    .wr_en_i   (wr_en),
    .wr_idx_i  (s1_idx_q),
    .wr_data_i (new_entry),
    .rd_data_o (cur_entry)
  );

  rbfd_vote u_vote (
    .samples_i (s1_samples_q),
    .vote_o    (vote)
  );

  always_comb begin
    new_entry              = cur_entry;
    new_entry.msg_cnt      = cur_entry.msg_cnt + CNT_W'(1);
    new_entry.samp_err_cnt = cur_entry.samp_err_cnt + CNT_W'(vote.uncertain);
    new_entry.par_err_cnt  = cur_entry.par_err_cnt + CNT_W'(vote.parity_failed);
    if (!vote.parity_failed) begin
      if (vote.payload[4]) begin
        new_entry.nib_hi = vote.payload;
      end else begin
        new_entry.nib_lo = vote.payload;
      end
    end
  end

  // gap selection
  logic err_gap_sel_q;
  logic err_gap_sel_d;

  assign err_gap_sel_d = s1_word_ok ? vote.parity_failed : err_gap_sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_gap_sel_q <= 1'b0;
    end else if (s1_adv) begin
      err_gap_sel_q <= err_gap_sel_d;
    end
  end

  // result register
  entry_t res_entry;

  always_comb begin
    if (!s1_ok_q) begin
      res_entry = '0;
    end else if (s1_mode_q == MODE_WORD) begin
      res_entry = new_entry;
    end else begin
      res_entry = cur_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (!out_valid_o || out_ready_i) begin
      out_valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      address_ok_o           <= s1_ok_q;
      address_o              <= s1_addr_q;
      payload_o              <= s1_word_ok ? vote.payload : '0;
      parity_failed_o        <= s1_word_ok && vote.parity_failed;
      samples_uncertain_o    <= s1_word_ok && vote.uncertain;
      gap_us_o               <= err_gap_sel_d ? error_gap_q : normal_gap_q;
      message_total_o        <= res_entry.msg_cnt[OUT_CNT_W-1:0];
      sampling_error_total_o <= res_entry.samp_err_cnt[OUT_CNT_W-1:0];
      parity_error_total_o   <= res_entry.par_err_cnt[OUT_CNT_W-1:0];
      stored_nibble_low_o    <= res_entry.nib_lo;
      stored_nibble_high_o   <= res_entry.nib_hi;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && parity_failed_o) |-> (payload_o == '0 && address_ok_o))
    else $error("parity failure with payload or bad address");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !address_ok_o) |->
      (message_total_o == '0 && parity_error_total_o == '0 && !samples_uncertain_o))
    else $error("dropped request reports status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !vote.parity_failed) |=> !err_gap_sel_q)
    else $error("good word left error gap selected");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_o && !out_ready_i))
    else $error("request stalled without a downstream stall");

endmodule

`default_nettype wire

FILE: hdl/rbfd_ram.sv
// ----------------------------------------------------------------------------
// rbfd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbfd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rbfd_vote.sv
// ----------------------------------------------------------------------------
// rbfd_vote
// Majority vote of the sample triplets, inversion and odd parity check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbfd_vote
  import rbfd_pkg::*;
(
  input  wire logic [SAMPLES_W-1:0] samples_i,
  output vote_t                     vote_o
);

  logic [DATA_BITS-1:0] voted;
  logic [DATA_BITS-1:0] mixed;
  logic [DATA_BITS-1:0] data;
  logic                 failed;

  always_comb begin
    for (int b = 0; b < DATA_BITS; b++) begin
      voted[b] = (samples_i[3*b] & samples_i[3*b+1]) |
                 (samples_i[3*b] & samples_i[3*b+2]) |
                 (samples_i[3*b+1] & samples_i[3*b+2]);
      // not unanimous: some sample differs from the others
      mixed[b] = (samples_i[3*b] | samples_i[3*b+1] | samples_i[3*b+2]) &
                 ~(samples_i[3*b] & samples_i[3*b+1] & samples_i[3*b+2]);
    end
  end

  assign data   = ~voted;
  assign failed = ~(^data);

  assign vote_o.payload       = failed ? '0 : data[NIB_W-1:0];
  assign vote_o.parity_failed = failed;
  assign vote_o.uncertain     = |mixed;

endmodule

`default_nettype wire

FILE: hdl/rbfd_status_store.sv
// ----------------------------------------------------------------------------
// rbfd_status_store
// Per-address status records: RAM, valid bits and write-to-read forwarding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbfd_status_store
  import rbfd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_en_i,
  input  wire logic [IDX_W-1:0] rd_idx_i,
  input  wire logic             wr_en_i,
  input  wire logic [IDX_W-1:0] wr_idx_i,
  input  wire entry_t           wr_data_i,
  output entry_t                rd_data_o
);

  logic [STORE_DEPTH-1:0] valid_q;
  logic                   rd_valid_q;
  logic                   fwd_hit_q;
  entry_t                 fwd_data_q;
  logic [ENTRY_W-1:0]     ram_rdata;

  rbfd_ram #(
    .Width (ENTRY_W),
    .Depth (STORE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en_i),
    .waddr_i (wr_idx_i),
    .wdata_i (wr_data_i),
    .re_i    (rd_en_i),
    .raddr_i (rd_idx_i),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_idx_i];
        // RAM returns old data on a same-edge write: take the write instead
        fwd_hit_q  <= wr_en_i && (wr_idx_i == rd_idx_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_data_q <= wr_data_i;
    end
  end

  always_comb begin
    if (fwd_hit_q) begin
      rd_data_o = fwd_data_q;
    end else if (rd_valid_q) begin
      rd_data_o = entry_t'(ram_rdata);
    end else begin
      rd_data_o = '0;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |=> valid_q[$past(wr_idx_i)])
    else $error("written entry not marked valid");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en_i && wr_en_i && (wr_idx_i == rd_idx_i)) |=> (rd_data_o == $past(wr_data_i)))
    else $error("same-edge write not forwarded to read");

endmodule

`default_nettype wire
